// File: rtl/core/lpcd_pkg.sv
// ============================================================================
// lpcd_pkg: shared types and constants for the command deframer
// Beat layouts, result kinds, frame status codes and default sizing.
// ============================================================================
package lpcd_pkg;

    localparam int LPCD_LENGTH_FIELD_BYTES = 4;
    localparam int LPCD_QUEUE_DEPTH        = 4;

    localparam logic [2:0] KIND_NAME       = 3'd0;
    localparam logic [2:0] KIND_ARG        = 3'd1;
    localparam logic [2:0] KIND_EMPTY_NAME = 3'd2;
    localparam logic [2:0] KIND_EMPTY_ARG  = 3'd3;
    localparam logic [2:0] KIND_STATUS     = 3'd4;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_FRAME  = 2'd1;
    localparam logic [1:0] STAT_TRUNCATED = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [7:0]  out_byte;
        logic [31:0] arg_number;
        logic        field_end;
        logic [1:0]  frame_status;
        logic        final_result;
    } t_out_beat;

    typedef struct packed {
        logic      v0;
        t_out_beat r0;
        logic      v1;
        t_out_beat r1;
    } t_push;

endpackage

// File: rtl/core/lpcd_parser.sv
// ============================================================================
// lpcd_parser: frame state tracking
// Consumes one buffer byte per beat and produces up to two result beats.
// ============================================================================
module lpcd_parser #(
    parameter int LENGTH_FIELD_BYTES = lpcd_pkg::LPCD_LENGTH_FIELD_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  lpcd_pkg::t_in_beat i_in,
    output lpcd_pkg::t_push    o_push
);

    localparam int CW = (LENGTH_FIELD_BYTES > 1) ? $clog2(LENGTH_FIELD_BYTES) : 1;

    typedef enum logic [2:0] {
        PH_NAME_LEN,
        PH_NAME_BODY,
        PH_ARGC,
        PH_ARG_LEN,
        PH_ARG_BODY,
        PH_DONE
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_hbc, n_hbc;
    logic [31:0]   r_asm, n_asm;
    logic [31:0]   r_body, n_body;
    logic [31:0]   r_args, n_args;
    logic [31:0]   r_cur, n_cur;

    logic [31:0] hbc32;
    logic [31:0] contrib;
    logic [31:0] len;
    logic        hdr_done;
    logic [31:0] body_dec;
    lpcd_pkg::t_out_beat res, stat;
    logic        res_v;
    logic [1:0]  status;

    assign hbc32    = 32'(r_hbc);
    assign contrib  = (hbc32 < 32'd4) ? (32'(i_in.data_byte) << {hbc32[1:0], 3'b000}) : 32'd0;
    assign len      = r_asm | contrib;
    assign hdr_done = (hbc32 == 32'(LENGTH_FIELD_BYTES - 1));
    assign body_dec = r_body - 32'd1;

    always_comb begin
        n_phase = r_phase;
        n_hbc   = r_hbc;
        n_asm   = r_asm;
        n_body  = r_body;
        n_args  = r_args;
        n_cur   = r_cur;
        res     = '0;
        res_v   = 1'b0;
        case (r_phase)
            PH_NAME_LEN, PH_ARGC, PH_ARG_LEN: begin
                if (!hdr_done) begin
                    n_hbc = CW'(r_hbc + 1'b1);
                    n_asm = len;
                end else begin
                    n_hbc = '0;
                    n_asm = '0;
                    if (r_phase == PH_NAME_LEN) begin
                        if (len == 32'd0) begin
                            res_v         = 1'b1;
                            res.out_kind  = lpcd_pkg::KIND_EMPTY_NAME;
                            res.field_end = 1'b1;
                            n_phase       = PH_ARGC;
                        end else begin
                            n_body  = len;
                            n_phase = PH_NAME_BODY;
                        end
                    end else if (r_phase == PH_ARGC) begin
                        n_args  = len;
                        n_cur   = '0;
                        n_phase = (len == 32'd0) ? PH_DONE : PH_ARG_LEN;
                    end else begin
                        if (len == 32'd0) begin
                            res_v          = 1'b1;
                            res.out_kind   = lpcd_pkg::KIND_EMPTY_ARG;
                            res.arg_number = r_cur;
                            res.field_end  = 1'b1;
                            n_cur          = r_cur + 32'd1;
                            n_args         = r_args - 32'd1;
                            n_phase        = (r_args == 32'd1) ? PH_DONE : PH_ARG_LEN;
                        end else begin
                            n_body  = len;
                            n_phase = PH_ARG_BODY;
                        end
                    end
                end
            end
            PH_NAME_BODY: begin
                n_body        = body_dec;
                res_v         = 1'b1;
                res.out_kind  = lpcd_pkg::KIND_NAME;
                res.out_byte  = i_in.data_byte;
                res.field_end = (body_dec == 32'd0);
                if (body_dec == 32'd0) begin
                    n_phase = PH_ARGC;
                end
            end
            PH_ARG_BODY: begin
                n_body         = body_dec;
                res_v          = 1'b1;
                res.out_kind   = lpcd_pkg::KIND_ARG;
                res.out_byte   = i_in.data_byte;
                res.arg_number = r_cur;
                res.field_end  = (body_dec == 32'd0);
                if (body_dec == 32'd0) begin
                    n_cur   = r_cur + 32'd1;
                    n_args  = r_args - 32'd1;
                    n_phase = (r_args == 32'd1) ? PH_DONE : PH_ARG_LEN;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        case (n_phase)
            PH_NAME_LEN:               status = lpcd_pkg::STAT_NO_FRAME;
            PH_NAME_BODY, PH_ARG_BODY: status = lpcd_pkg::STAT_TRUNCATED;
            default:                   status = lpcd_pkg::STAT_OK;
        endcase

        stat              = '0;
        stat.out_kind     = lpcd_pkg::KIND_STATUS;
        stat.frame_status = status;
        stat.final_result = 1'b1;

        if (i_in.last_byte) begin
            n_phase = PH_NAME_LEN;
            n_hbc   = '0;
            n_asm   = '0;
            n_body  = '0;
            n_args  = '0;
            n_cur   = '0;
        end
    end

    always_comb begin
        o_push    = '0;
        o_push.r0 = res;
        o_push.r1 = stat;
        o_push.v0 = i_fire && res_v;
        o_push.v1 = i_fire && i_in.last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NAME_LEN;
            r_hbc   <= '0;
            r_asm   <= '0;
            r_body  <= '0;
            r_args  <= '0;
            r_cur   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_hbc   <= n_hbc;
            r_asm   <= n_asm;
            r_body  <= n_body;
            r_args  <= n_args;
            r_cur   <= n_cur;
        end
    end

    a_hbc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hbc) < 32'(LENGTH_FIELD_BYTES))
        else $error("header byte count out of range");

    a_hbc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_NAME_BODY || r_phase == PH_ARG_BODY || r_phase == PH_DONE)
        |-> (r_hbc == '0))
        else $error("header count left over outside a length field");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_in.last_byte) |=> (r_phase == PH_NAME_LEN && r_cur == '0))
        else $error("state not cleared after last byte");

    a_body_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_NAME_BODY || r_phase == PH_ARG_BODY) |-> (r_body != '0))
        else $error("body phase with nothing due");

endmodule

// File: rtl/core/lpcd_result_fifo.sv
// ============================================================================
// lpcd_result_fifo: result queue
// Takes up to two result beats per cycle, hands out one per cycle while not stalled.
// ============================================================================
module lpcd_result_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lpcd_pkg::t_push     i_push,
    output logic                o_room,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lpcd_pkg::t_out_beat o_out_data
);

    localparam int DEPTH = lpcd_pkg::LPCD_QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    lpcd_pkg::t_out_beat mem [DEPTH];

    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [NW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] wp_b;
    logic          pop;
    logic [1:0]    n_push;

    assign pop         = (r_cnt != '0) && !i_out_stall;
    assign n_push      = {1'b0, i_push.v0} + {1'b0, i_push.v1};
    assign wp_b        = i_push.v0 ? PW'(r_wp + 1'b1) : r_wp;
    assign n_wp        = PW'(r_wp + NW'(n_push));
    assign n_rp        = pop ? PW'(r_rp + 1'b1) : r_rp;
    assign n_cnt       = NW'(r_cnt + NW'(n_push) - NW'(pop));
    assign o_room      = (r_cnt <= NW'(DEPTH - 2));
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            mem[r_wp] <= i_push.r0;
        end
        if (i_push.v1) begin
            mem[wp_b] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_push != 2'd0) |-> (32'(r_cnt) + 32'(n_push) <= 32'(DEPTH)))
        else $error("result queue overflow");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= 32'(DEPTH))
        else $error("result queue count out of range");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != NW'(DEPTH)) |-> (PW'(r_wp - r_rp) == PW'(r_cnt)))
        else $error("queue pointers disagree with count");

endmodule

// File: rtl/core/length_prefixed_command_deframer.sv
// ============================================================================
// length_prefixed_command_deframer: length-prefixed command frame parser
// Splits a byte stream of name length, name, argument count and arguments
// into tagged name and argument bytes, empty-field markers and a status.
// ============================================================================
// One buffer byte is taken per cycle while the input is not stalled. Each beat
// passes an input register, then the parser state update, which writes its
// results into a four-entry result queue; a result is valid at the output once
// it has been written into the queue. A byte gives at most two results (the
// last byte of the buffer adds the frame status), and the result side hands
// out one beat per cycle unless the output is stalled, so the input stalls
// only while the queue holds more than two beats. Length fields are
// LENGTH_FIELD_BYTES bytes, little-endian; bytes beyond the fourth are skipped.
module length_prefixed_command_deframer #(
    parameter int LENGTH_FIELD_BYTES = lpcd_pkg::LPCD_LENGTH_FIELD_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lpcd_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lpcd_pkg::t_out_beat o_out_data
);

    logic               r_in_valid;
    lpcd_pkg::t_in_beat r_in;
    logic               room;
    logic               fire;
    lpcd_pkg::t_push    push;

    assign fire       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    lpcd_parser #(
        .LENGTH_FIELD_BYTES(LENGTH_FIELD_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_in    (r_in),
        .o_push  (push)
    );

    lpcd_result_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_valid)
        else $error("input register lost a stalled beat");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.v1 |-> (fire && r_in.last_byte))
        else $error("status pushed without a last byte");

    a_fire_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(r_in))
        else $error("held input beat changed");

endmodule
